@@ design/lcga_pkg.sv @@
// ----------------------------------------------------------------------------
// lcga_pkg
// Shared types, constants and helpers of the least cost greedy allocator.
// ----------------------------------------------------------------------------
package lcga_pkg;

    localparam int MAX_SIZE    = 16;
    localparam int LINE_LIMIT  = 16;
    localparam int SIZE_LIMIT  = (MAX_SIZE < LINE_LIMIT) ? MAX_SIZE : LINE_LIMIT;
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(LINE_LIMIT);
    localparam int SIZE_W      = 5;
    localparam int UNITS_W     = 16;
    localparam int COST_W      = 16;
    localparam int BEST_W      = 17;
    localparam int PROD_W      = UNITS_W + COST_W;
    localparam int TOTAL_W     = 48;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BEST_W-1:0]    NO_CHOICE = BEST_W'(99999);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS = 1'b1;

    typedef struct packed {
        logic [COST_W-1:0] cell_cost;
        logic              last_cell;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   source_row;
        logic [IDX_W-1:0]   dest_col;
        logic [COST_W-1:0]  chosen_cost;
        logic [TOTAL_W-1:0] running_total;
        logic               last_pick;
    } out_item_t;

    typedef struct packed {
        logic load_wr;
        logic start;
        logic scan;
        logic mul;
        logic emit;
        logic round_init;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic last_round;
        logic slot_free;
    } dp_sts_t;

    function automatic logic [IDX_W-1:0] size_minus_one(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        begin
            n = size;
            if (n == '0)
            begin
                n = SIZE_W'(1);
            end
            if (n > SIZE_W'(SIZE_LIMIT))
            begin
                n = SIZE_W'(SIZE_LIMIT);
            end
            return IDX_W'(n - SIZE_W'(1));
        end
    endfunction

endpackage

@@ design/least_cost_greedy_allocator_unit.sv @@
// Load: a matrix of size n loads one cell per cycle until the final cell. Each
// allocation round then scans with one store read per cell, multiplies and emits.
// Result: n allocations per n*n cells loaded; no input is taken during allocation.
// Reset: all rows and columns open, load position and running total at zero,
// size 16 and one unit per line; the cost store is not cleared.
// ----------------------------------------------------------------------------
// least_cost_greedy_allocator_unit
// Least cost cell allocation over a loaded square cost matrix.
// ----------------------------------------------------------------------------
module least_cost_greedy_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lcga_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcga_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lcga_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lcga_pkg::out_item_t            out_item
);

    lcga_pkg::dp_cmd_t cmd;
    lcga_pkg::dp_sts_t sts;

    lcga_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_cell (in_item.last_cell),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lcga_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.last_cell) |=> !in_ready)
        else $error("Input still accepted after the final cell.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("Allocation overwrote a pending transaction.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("Pending result transaction changed before it was taken.");

endmodule

@@ design/lcga_ram.sv @@
// ----------------------------------------------------------------------------
// lcga_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/lcga_datapath.sv @@
// ----------------------------------------------------------------------------
// lcga_datapath
// Cost store, scan counters, minimum search, line flags, total and output.
// ----------------------------------------------------------------------------
module lcga_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lcga_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcga_pkg::CFG_W-1:0]          cfg_data,
    input  lcga_pkg::in_item_t                  in_item,
    output lcga_pkg::out_item_t                 out_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  lcga_pkg::dp_cmd_t                   cmd,
    output lcga_pkg::dp_sts_t                   sts
);

    logic [lcga_pkg::SIZE_W-1:0]     size_reg;
    logic [lcga_pkg::UNITS_W-1:0]    units_reg;
    logic [lcga_pkg::ADDR_W-1:0]     load_idx_reg;
    logic [lcga_pkg::IDX_W-1:0]      nm1_reg;
    logic [lcga_pkg::IDX_W-1:0]      row_reg;
    logic [lcga_pkg::IDX_W-1:0]      col_reg;
    logic [lcga_pkg::ADDR_W-1:0]     addr_reg;
    logic                            rd_valid_reg;
    logic [lcga_pkg::IDX_W-1:0]      row_d_reg;
    logic [lcga_pkg::IDX_W-1:0]      col_d_reg;
    logic [lcga_pkg::BEST_W-1:0]     best_reg;
    logic [lcga_pkg::IDX_W-1:0]      best_row_reg;
    logic [lcga_pkg::IDX_W-1:0]      best_col_reg;
    logic [lcga_pkg::LINE_LIMIT-1:0] row_open_reg;
    logic [lcga_pkg::LINE_LIMIT-1:0] col_open_reg;
    logic [lcga_pkg::IDX_W-1:0]      round_reg;
    logic [lcga_pkg::PROD_W-1:0]     product_reg;
    logic [lcga_pkg::TOTAL_W-1:0]    total_reg;
    logic [lcga_pkg::TOTAL_W-1:0]    total_next;
    logic [lcga_pkg::TOTAL_W:0]      total_sum;
    logic                            out_valid_reg;
    lcga_pkg::out_item_t             out_item_reg;
    logic [lcga_pkg::COST_W-1:0]     rd_data;
    logic                            take;

    lcga_ram #(
        .WIDTH (lcga_pkg::COST_W),
        .DEPTH (lcga_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.load_wr),
        .wr_addr (load_idx_reg),
        .wr_data (in_item.cell_cost),
        .rd_en   (cmd.scan),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        take = rd_valid_reg && row_open_reg[row_d_reg] && col_open_reg[col_d_reg]
            && ({1'b0, rd_data} < best_reg);
        total_sum  = {1'b0, total_reg} + (lcga_pkg::TOTAL_W + 1)'(product_reg);
        total_next = total_sum[lcga_pkg::TOTAL_W] ? '1 : total_sum[lcga_pkg::TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= lcga_pkg::SIZE_W'(16);
            units_reg     <= lcga_pkg::UNITS_W'(1);
            load_idx_reg  <= '0;
            nm1_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            row_d_reg     <= '0;
            col_d_reg     <= '0;
            best_reg      <= lcga_pkg::NO_CHOICE;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
            row_open_reg  <= '1;
            col_open_reg  <= '1;
            round_reg     <= '0;
            product_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lcga_pkg::CFG_SIZE:  size_reg  <= cfg_data[lcga_pkg::SIZE_W-1:0];
                    lcga_pkg::CFG_UNITS: units_reg <= cfg_data[lcga_pkg::UNITS_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.load_wr)
            begin
                load_idx_reg <= cmd.start ? '0 : load_idx_reg + lcga_pkg::ADDR_W'(1);
            end

            rd_valid_reg <= cmd.scan;
            if (cmd.scan)
            begin
                row_d_reg <= row_reg;
                col_d_reg <= col_reg;
                addr_reg  <= addr_reg + lcga_pkg::ADDR_W'(1);
                if (col_reg == nm1_reg)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + lcga_pkg::IDX_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + lcga_pkg::IDX_W'(1);
                end
            end

            if (take)
            begin
                best_reg     <= {1'b0, rd_data};
                best_row_reg <= row_d_reg;
                best_col_reg <= col_d_reg;
            end

            if (cmd.mul)
            begin
                product_reg <= lcga_pkg::PROD_W'(units_reg)
                    * lcga_pkg::PROD_W'(best_reg[lcga_pkg::COST_W-1:0]);
            end

            if (cmd.emit)
            begin
                out_item_reg.source_row    <= best_row_reg;
                out_item_reg.dest_col      <= best_col_reg;
                out_item_reg.chosen_cost   <= best_reg[lcga_pkg::COST_W-1:0];
                out_item_reg.running_total <= total_next;
                out_item_reg.last_pick     <= (round_reg == nm1_reg);
                total_reg                  <= total_next;
                row_open_reg[best_row_reg] <= 1'b0;
                col_open_reg[best_col_reg] <= 1'b0;
                round_reg                  <= round_reg + lcga_pkg::IDX_W'(1);
                out_valid_reg              <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.start || cmd.round_init)
            begin
                row_reg  <= '0;
                col_reg  <= '0;
                addr_reg <= '0;
                best_reg <= lcga_pkg::NO_CHOICE;
            end

            if (cmd.start)
            begin
                nm1_reg      <= lcga_pkg::size_minus_one(size_reg);
                row_open_reg <= '1;
                col_open_reg <= '1;
                round_reg    <= '0;
            end
        end
    end

    assign sts.scan_last  = (row_reg == nm1_reg) && (col_reg == nm1_reg);
    assign sts.last_round = (round_reg == nm1_reg);
    assign sts.slot_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_item       = out_item_reg;

endmodule

@@ design/lcga_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcga_ctrl
// Sequencer for loading, scanning rounds and issuing allocations.
// ----------------------------------------------------------------------------
module lcga_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_cell,
    output logic               in_ready,
    input  lcga_pkg::dp_sts_t  sts,
    output lcga_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (last_cell)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_round)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.round_init = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
